// ===== hdl/tlsg_pkg.sv =====
// Shared types, widths and helpers for the tetrahedron shape-gradient block.
package tlsg_pkg;

	localparam int COORD_W       = 32;
	localparam int EDGE_W        = COORD_W + 1;
	localparam int COF_W         = 2 * EDGE_W + 1;
	localparam int PROD_W        = 100;
	localparam int DET_W         = 102;
	localparam int GRAD_W        = 32;
	localparam int DETQ_W        = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] IDX_LAST = 2'd2;
	localparam logic [1:0] ROW_LAST = 2'd3;

	typedef struct packed {
		logic [2:0][2:0][EDGE_W-1:0] e;
	} edges_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COF_A,
		ST_COF_B,
		ST_DET,
		ST_CHK,
		ST_DIV,
		ST_SUM,
		ST_OUT
	} back_state_t;

	function automatic logic [1:0] mod3_inc(input logic [1:0] v);
		return (v == IDX_LAST) ? 2'd0 : v + 2'd1;
	endfunction

endpackage

// ===== hdl/tlsg_in_if.sv =====
// Input channel: four vertex coordinates per transaction.
interface tlsg_in_if import tlsg_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] v0_x, v0_y, v0_z;
	logic signed [COORD_W-1:0] v1_x, v1_y, v1_z;
	logic signed [COORD_W-1:0] v2_x, v2_y, v2_z;
	logic signed [COORD_W-1:0] v3_x, v3_y, v3_z;

	modport source(output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, input ready);
	modport sink(input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, output ready);
endinterface

// ===== hdl/tlsg_out_if.sv =====
// Output channel: one gradient row per transaction.
interface tlsg_out_if import tlsg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               vertex_index;
	logic signed [GRAD_W-1:0] grad_x, grad_y, grad_z;
	logic signed [DETQ_W-1:0] jac_det;
	logic                     degenerate;
	logic                     last_row;

	modport source(output valid, vertex_index, grad_x, grad_y, grad_z, jac_det,
		degenerate, last_row, input ready);
	modport sink(input valid, vertex_index, grad_x, grad_y, grad_z, jac_det,
		degenerate, last_row, output ready);
endinterface

// ===== hdl/tlsg_front.sv =====
// Front end: accepts vertices and registers the edge vectors from vertex 0 to each other vertex.
module tlsg_front import tlsg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	tlsg_in_if.sink in_ch,
	output edges_t edges,
	output logic   edges_valid,
	input  logic   edges_ready
);

	edges_t edges_d;
	edges_t edges_s1;
	logic   valid_s1;
	logic   accept;

	function automatic logic [EDGE_W-1:0] diff(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

	always_comb begin
		edges_d.e[0][0] = diff(in_ch.v1_x, in_ch.v0_x);
		edges_d.e[0][1] = diff(in_ch.v1_y, in_ch.v0_y);
		edges_d.e[0][2] = diff(in_ch.v1_z, in_ch.v0_z);
		edges_d.e[1][0] = diff(in_ch.v2_x, in_ch.v0_x);
		edges_d.e[1][1] = diff(in_ch.v2_y, in_ch.v0_y);
		edges_d.e[1][2] = diff(in_ch.v2_z, in_ch.v0_z);
		edges_d.e[2][0] = diff(in_ch.v3_x, in_ch.v0_x);
		edges_d.e[2][1] = diff(in_ch.v3_y, in_ch.v0_y);
		edges_d.e[2][2] = diff(in_ch.v3_z, in_ch.v0_z);
	end

	assign in_ch.ready = !valid_s1 || edges_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (edges_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			edges_s1 <= edges_d;
		end
	end

	assign edges       = edges_s1;
	assign edges_valid = valid_s1;

endmodule

// ===== hdl/tlsg_fifo.sv =====
// Short queue of edge sets between front and back end.
module tlsg_fifo import tlsg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  edges_t wr_data,
	input  logic   wr_valid,
	output logic   wr_ready,
	output edges_t rd_data,
	output logic   rd_valid,
	input  logic   rd_ready
);

	edges_t            mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push, pop;

	assign wr_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/tlsg_back.sv =====
// Back end: serial cofactors, determinant, divisions and four output rows.
module tlsg_back import tlsg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  edges_t q_edges,
	input  logic   q_valid,
	output logic   q_ready,
	tlsg_out_if.source out_ch
);

	localparam int NUM_W = COF_W + 2 * FRAC_BITS + 2;
	localparam int DEN_W = DET_W + 1;
	localparam int REM_W = DEN_W + 1;
	localparam int GR_W  = NUM_W + 3;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int DSH   = 3 * FRAC_BITS - 32;
	localparam int DQ_W  = DET_W + 9;

	back_state_t state_q, state_d;
	logic [1:0]  k_q, c_q, row_q;
	logic [1:0]  k1, k2, c1, c2;

	logic signed [EDGE_W-1:0] e_q   [3][3];
	logic signed [COF_W-1:0]  cof_q [3][3];
	logic signed [GR_W-1:0]   g_q   [3][3];
	logic signed [GR_W-1:0]   g0_q  [3];
	logic signed [DET_W-1:0]  det_q;
	logic signed [PROD_W:0]   tmp_q;
	logic                     degen_q;
	logic [DETQ_W-1:0]        detq_q;

	// serial multiplier
	logic [PROD_W-1:0]        mcand_q, acc_q;
	logic [COF_W-1:0]         mplier_q;
	logic                     mneg_q, mbusy_q;
	logic signed [EDGE_W-1:0] a_op;
	logic signed [COF_W-1:0]  b_op;
	logic [EDGE_W-1:0]        a_mag;
	logic [COF_W-1:0]         b_mag;
	logic signed [PROD_W:0]   prod;
	logic                     mul_start, mul_done;

	// restoring divider
	logic [NUM_W-1:0]         num_q, quo_q;
	logic [DEN_W-1:0]         den_q;
	logic [REM_W-1:0]         rem_q, rem_sh;
	logic [CNT_W-1:0]         dcnt_q;
	logic                     dneg_q, dbusy_q, div_start, div_done, qbit;
	logic signed [COF_W-1:0]  cv;
	logic [COF_W-1:0]         c_mag;
	logic [DET_W-1:0]         d_mag;
	logic signed [GR_W-1:0]   quo_s;

	logic [DQ_W-1:0]          dmag;
	logic signed [DQ_W:0]     dq_s;
	logic                     det_zero, out_load, ov_q;
	logic signed [GR_W-1:0]   sel_x, sel_y, sel_z;

	function automatic logic [GRAD_W-1:0] sat_grad(input logic [GR_W-1:0] v);
		if (v[GR_W-1:GRAD_W-1] == '0 || v[GR_W-1:GRAD_W-1] == '1) begin
			return v[GRAD_W-1:0];
		end
		return v[GR_W-1] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
	endfunction

	function automatic logic [DETQ_W-1:0] sat_det(input logic [DQ_W:0] v);
		if (v[DQ_W:DETQ_W-1] == '0 || v[DQ_W:DETQ_W-1] == '1) begin
			return v[DETQ_W-1:0];
		end
		return v[DQ_W] ? {1'b1, {(DETQ_W-1){1'b0}}} : {1'b0, {(DETQ_W-1){1'b1}}};
	endfunction

	assign k1 = mod3_inc(k_q);
	assign k2 = mod3_inc(k1);
	assign c1 = mod3_inc(c_q);
	assign c2 = mod3_inc(c1);

	always_comb begin
		a_op = e_q[0][c_q];
		b_op = cof_q[0][c_q];
		unique case (state_q)
			ST_COF_A: begin
				a_op = e_q[k1][c1];
				b_op = COF_W'(e_q[k2][c2]);
			end
			ST_COF_B: begin
				a_op = e_q[k1][c2];
				b_op = COF_W'(e_q[k2][c1]);
			end
			default: begin
			end
		endcase
	end

	assign a_mag    = a_op[EDGE_W-1] ? EDGE_W'(-a_op) : EDGE_W'(a_op);
	assign b_mag    = b_op[COF_W-1] ? COF_W'(-b_op) : COF_W'(b_op);
	assign mul_done = mbusy_q && (mplier_q == '0);
	assign prod     = mneg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

	assign cv       = cof_q[k_q][c_q];
	assign c_mag    = cv[COF_W-1] ? COF_W'(-cv) : COF_W'(cv);
	assign d_mag    = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
	assign rem_sh   = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign qbit     = rem_sh >= REM_W'(den_q);
	assign div_done = dbusy_q && (dcnt_q == '0);
	assign quo_s    = dneg_q ? -$signed(GR_W'(quo_q)) : $signed(GR_W'(quo_q));
	assign det_zero = det_q == '0;

	generate
		if (DSH > 0) begin : g_det_rshift
			assign dmag = (DQ_W'(d_mag) + (DQ_W'(1) << (DSH - 1))) >> DSH;
		end else begin : g_det_lshift
			assign dmag = DQ_W'(d_mag) << (-DSH);
		end
	endgenerate

	assign dq_s = det_q[DET_W-1] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid) state_d = ST_COF_A;
			ST_COF_A: if (mul_done) state_d = ST_COF_B;
			ST_COF_B: begin
				if (mul_done) begin
					state_d = (k_q == IDX_LAST && c_q == IDX_LAST) ? ST_DET : ST_COF_A;
				end
			end
			ST_DET:   if (mul_done && c_q == IDX_LAST) state_d = ST_CHK;
			ST_CHK:   state_d = det_zero ? ST_OUT : ST_DIV;
			ST_DIV: begin
				if (div_done && k_q == IDX_LAST && c_q == IDX_LAST) state_d = ST_SUM;
			end
			ST_SUM:   state_d = ST_OUT;
			ST_OUT:   if (out_load && row_q == ROW_LAST) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_ready   = state_q == ST_IDLE;
		mul_start = (state_q == ST_COF_A || state_q == ST_COF_B || state_q == ST_DET)
			&& !mbusy_q;
		div_start = state_q == ST_DIV && !dbusy_q;
		out_load  = state_q == ST_OUT && (!ov_q || out_ch.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			c_q     <= '0;
			row_q   <= '0;
			mbusy_q <= 1'b0;
			dbusy_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start) begin
				mbusy_q <= 1'b1;
			end else if (mul_done) begin
				mbusy_q <= 1'b0;
			end
			if (div_start) begin
				dbusy_q <= 1'b1;
			end else if (div_done) begin
				dbusy_q <= 1'b0;
			end
			if ((state_q == ST_COF_B && mul_done) || (state_q == ST_DIV && div_done)) begin
				if (c_q == IDX_LAST) begin
					c_q <= '0;
					k_q <= (k_q == IDX_LAST) ? 2'd0 : k_q + 2'd1;
				end else begin
					c_q <= c_q + 2'd1;
				end
			end else if (state_q == ST_DET && mul_done) begin
				c_q <= (c_q == IDX_LAST) ? 2'd0 : c_q + 2'd1;
			end else if (state_q == ST_IDLE) begin
				k_q <= '0;
				c_q <= '0;
			end
			if (out_load) begin
				row_q <= row_q + 2'd1;
				ov_q  <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					e_q[i][j] <= q_edges.e[i][j];
				end
			end
			det_q <= '0;
		end
		if (mul_start) begin
			mcand_q  <= PROD_W'(a_mag);
			mplier_q <= b_mag;
			acc_q    <= '0;
			mneg_q   <= a_op[EDGE_W-1] ^ b_op[COF_W-1];
		end else if (mbusy_q && !mul_done) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[COF_W-1:1]};
		end
		if (state_q == ST_COF_A && mul_done) begin
			tmp_q <= prod;
		end
		if (state_q == ST_COF_B && mul_done) begin
			cof_q[k_q][c_q] <= COF_W'(tmp_q - prod);
		end
		if (state_q == ST_DET && mul_done) begin
			det_q <= det_q + DET_W'(prod);
		end
		if (state_q == ST_CHK) begin
			degen_q <= det_zero;
			detq_q  <= sat_det(dq_s);
		end
		if (div_start) begin
			num_q  <= (NUM_W'(c_mag) << (2 * FRAC_BITS + 1)) + NUM_W'(d_mag);
			den_q  <= {d_mag, 1'b0};
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= CNT_W'(NUM_W);
			dneg_q <= cv[COF_W-1] ^ det_q[DET_W-1];
		end else if (dbusy_q && !div_done) begin
			rem_q  <= qbit ? rem_sh - REM_W'(den_q) : rem_sh;
			quo_q  <= {quo_q[NUM_W-2:0], qbit};
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			dcnt_q <= dcnt_q - CNT_W'(1);
		end
		if (state_q == ST_DIV && div_done) begin
			g_q[k_q][c_q] <= quo_s;
		end
		if (state_q == ST_SUM) begin
			for (int j = 0; j < 3; j++) begin
				g0_q[j] <= -(g_q[0][j] + g_q[1][j] + g_q[2][j]);
			end
		end
		if (out_load) begin
			out_ch.vertex_index <= row_q;
			out_ch.grad_x       <= degen_q ? '0 : sat_grad(sel_x);
			out_ch.grad_y       <= degen_q ? '0 : sat_grad(sel_y);
			out_ch.grad_z       <= degen_q ? '0 : sat_grad(sel_z);
			out_ch.jac_det      <= detq_q;
			out_ch.degenerate   <= degen_q;
			out_ch.last_row     <= row_q == ROW_LAST;
		end
	end

	always_comb begin
		if (row_q == '0) begin
			sel_x = g0_q[0];
			sel_y = g0_q[1];
			sel_z = g0_q[2];
		end else begin
			sel_x = g_q[row_q - 2'd1][0];
			sel_y = g_q[row_q - 2'd1][1];
			sel_z = g_q[row_q - 2'd1][2];
		end
	end

	assign out_ch.valid = ov_q;

`ifndef NO_ASSERTIONS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && dbusy_q) |-> den_q != '0)
		else $error("divider running with zero denominator");
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (out_ch.last_row == (out_ch.vertex_index == ROW_LAST)))
		else $error("last_row out of step with vertex_index");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_ch.degenerate) |->
		(out_ch.grad_x == '0 && out_ch.grad_y == '0 && out_ch.grad_z == '0))
		else $error("degenerate row with nonzero gradient");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mbusy_q && dbusy_q))
		else $error("multiplier and divider busy together");
`endif

endmodule

// ===== hdl/tet_linear_shape_gradients.sv =====
// Top level: linear tetrahedron shape-function gradients in fixed point.
// Work from input to first row: 18 cofactor multiplies, 3 determinant multiplies and 9 divides,
// plus the front register, queue and control states.
// Throughput: one tetrahedron per back-end pass, set by the shared bit-serial multiplier and
// divider. Four result rows per item.
// Reset: arst_n clears all control state; the queue and output go empty.
module tet_linear_shape_gradients import tlsg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tlsg_in_if.sink     in_ch,
	tlsg_out_if.source  out_ch
);

	edges_t f_edges, q_edges;
	logic   f_valid, f_ready, q_valid, q_ready;

	tlsg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.edges       (f_edges),
		.edges_valid (f_valid),
		.edges_ready (f_ready)
	);

	tlsg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (f_edges),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_data  (q_edges),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	tlsg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_edges (q_edges),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.out_ch  (out_ch)
	);

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the tetrahedron shape-gradient block.
`timescale 1ns / 1ps

module testbench;
	import tlsg_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 6000;

	typedef logic signed [255:0] wide_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct {
		coord_t v [4][3];
	} tet_t;

	typedef struct {
		logic [1:0]               vertex_index;
		logic signed [GRAD_W-1:0] grad [3];
		logic signed [DETQ_W-1:0] jac_det;
		logic                     degenerate;
		logic                     last_row;
	} grad_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlsg_in_if  in_ch();
	tlsg_out_if out_ch();

	tet_linear_shape_gradients uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	grad_row_t expected_rows[$];
	int        errors = 0;
	int        sent_tets = 0;
	int        checked_rows = 0;
	int        flat_tets = 0;
	int        send_idle = 0;
	int        recv_idle = 0;
	int        quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		{in_ch.v0_x, in_ch.v0_y, in_ch.v0_z, in_ch.v1_x, in_ch.v1_y, in_ch.v1_z} = '0;
		{in_ch.v2_x, in_ch.v2_y, in_ch.v2_z, in_ch.v3_x, in_ch.v3_y, in_ch.v3_z} = '0;
		out_ch.ready = 1'b0;
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	function automatic logic signed [GRAD_W-1:0] sat32(wide_t v);
		if (v[255:31] == '0 || v[255:31] == '1)
			return v[31:0];
		return v[255] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	function automatic logic signed [DETQ_W-1:0] sat64(wide_t v);
		if (v[255:63] == '0 || v[255:63] == '1)
			return v[63:0];
		return v[255] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
	endfunction

	function automatic wide_t abs_w(wide_t v);
		return v[255] ? -v : v;
	endfunction

	// nearest, ties away from zero
	function automatic wide_t div_round(wide_t n, wide_t d);
		wide_t an, ad, q;
		an = abs_w(n);
		ad = abs_w(d);
		q = ((an <<< 1) + ad) / (ad <<< 1);
		return (n[255] != d[255]) ? -q : q;
	endfunction

	task automatic predict_gradients(input tet_t t);
		wide_t     e [3][3];
		wide_t     cof [3][3];
		wide_t     g [4][3];
		wide_t     det, mag;
		grad_row_t row;
		logic      flat;
		for (int i = 0; i < 3; i++)
			for (int c = 0; c < 3; c++)
				e[i][c] = wide_t'(t.v[i+1][c]) - wide_t'(t.v[0][c]);
		for (int k = 0; k < 3; k++)
			for (int c = 0; c < 3; c++)
				cof[k][c] = e[(k+1)%3][(c+1)%3] * e[(k+2)%3][(c+2)%3]
					- e[(k+1)%3][(c+2)%3] * e[(k+2)%3][(c+1)%3];
		det = 0;
		for (int c = 0; c < 3; c++)
			det = det + e[0][c] * cof[0][c];
		flat = (det == 0);
		for (int i = 0; i < 4; i++)
			for (int c = 0; c < 3; c++)
				g[i][c] = 0;
		row.jac_det = '0;
		if (!flat) begin
			for (int k = 0; k < 3; k++)
				for (int c = 0; c < 3; c++)
					g[k+1][c] = div_round(cof[k][c] <<< (2 * FRAC_BITS_DEF), det);
			for (int c = 0; c < 3; c++)
				g[0][c] = -(g[1][c] + g[2][c] + g[3][c]);
			mag = (abs_w(det) + (wide_t'(1) <<< 15)) >>> 16;
			row.jac_det = sat64(det[255] ? -mag : mag);
		end else begin
			flat_tets++;
		end
		for (int i = 0; i < 4; i++) begin
			row.vertex_index = i[1:0];
			for (int c = 0; c < 3; c++)
				row.grad[c] = sat32(g[i][c]);
			row.degenerate = flat;
			row.last_row = (i == 3);
			expected_rows.push_back(row);
		end
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] want,
		input logic [63:0] got);
		errors++;
		$display("mismatch at %0t: %s expected %h got %h", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			grad_row_t want;
			if (expected_rows.size() == 0) begin
				errors++;
				$display("mismatch at %0t: unexpected result transaction", $time);
			end else begin
				want = expected_rows.pop_front();
				checked_rows++;
				if (out_ch.vertex_index !== want.vertex_index)
					report_mismatch("vertex_index", want.vertex_index, out_ch.vertex_index);
				if (out_ch.grad_x !== want.grad[0])
					report_mismatch("grad_x", want.grad[0], out_ch.grad_x);
				if (out_ch.grad_y !== want.grad[1])
					report_mismatch("grad_y", want.grad[1], out_ch.grad_y);
				if (out_ch.grad_z !== want.grad[2])
					report_mismatch("grad_z", want.grad[2], out_ch.grad_z);
				if (out_ch.jac_det !== want.jac_det)
					report_mismatch("jac_det", want.jac_det, out_ch.jac_det);
				if (out_ch.degenerate !== want.degenerate)
					report_mismatch("degenerate", want.degenerate, out_ch.degenerate);
				if (out_ch.last_row !== want.last_row)
					report_mismatch("last_row", want.last_row, out_ch.last_row);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d rows outstanding", expected_rows.size());
			$display("status: fail");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_tet(input tet_t t);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.v0_x, in_ch.v0_y, in_ch.v0_z} <= {t.v[0][0], t.v[0][1], t.v[0][2]};
		{in_ch.v1_x, in_ch.v1_y, in_ch.v1_z} <= {t.v[1][0], t.v[1][1], t.v[1][2]};
		{in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} <= {t.v[2][0], t.v[2][1], t.v[2][2]};
		{in_ch.v3_x, in_ch.v3_y, in_ch.v3_z} <= {t.v[3][0], t.v[3][1], t.v[3][2]};
		do @(posedge clk); while (!in_ch.ready);
		predict_gradients(t);
		sent_tets++;
		@(negedge clk);
	endtask

	function automatic tet_t tet_of(input coord_t base, input coord_t s1, input coord_t s2,
		input coord_t s3);
		tet_t t;
		for (int c = 0; c < 3; c++) begin
			t.v[0][c] = base;
			t.v[1][c] = base;
			t.v[2][c] = base;
			t.v[3][c] = base;
		end
		t.v[1][0] = base + s1;
		t.v[2][1] = base + s2;
		t.v[3][2] = base + s3;
		return t;
	endfunction

	function automatic coord_t rand_span(input int unsigned span);
		return coord_t'($urandom_range(2 * span)) - coord_t'(span);
	endfunction

	task automatic test_directed();
		tet_t t;
		send_tet(tet_of(0, 0, 0, 0));
		send_tet(tet_of(0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
		send_tet(tet_of(32'sh10_0000, -32'sh2_0000, 32'sh3_0000, 32'sh0_8000));
		// tiny volume: determinant rounds to zero but block is not degenerate
		send_tet(tet_of(32'sh1234, 1, 1, 1));
		send_tet(tet_of(-32'sh1234, 1, -1, 3));
		// full-range edges: determinant saturates, except one case with repeated vertices that is degenerate
		send_tet(tet_of(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
		send_tet(tet_of(32'sh7fff_ffff, 32'sh8000_0001, 32'sh8000_0001, 32'sh8000_0001));
		for (int i = 0; i < 4; i++)
			for (int c = 0; c < 3; c++)
				t.v[i][c] = ((i + c) % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
		send_tet(t);
		for (int i = 0; i < 4; i++)
			for (int c = 0; c < 3; c++)
				t.v[i][c] = (i == c + 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
		send_tet(t);
		// repeated-vertex and coplanar points, then an ordinary tetrahedron
		send_tet(tet_of(32'sh5_0000, 32'sh1_0000, 0, 32'sh2_0000));
		for (int c = 0; c < 3; c++) begin
			t.v[0][c] = 32'sh1_0000 * (c + 1);
			t.v[1][c] = 32'sh2_0000 * c;
			t.v[2][c] = -32'sh3_0000 + c;
			t.v[3][c] = t.v[1][c] + t.v[2][c] - t.v[0][c];
		end
		send_tet(t);
		send_tet(tet_of(32'shffff_ffff, -32'sh0001_0000, 32'sh0000_8000, -32'sh0002_0000));
	endtask

	task automatic test_random(input int count);
		tet_t t;
		coord_t base;
		int unsigned span;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					for (int i = 0; i < 4; i++)
						for (int c = 0; c < 3; c++)
							t.v[i][c] = $signed($urandom());
				end
				3: begin
					for (int c = 0; c < 3; c++) begin
						t.v[0][c] = rand_span(1 << 24);
						t.v[1][c] = rand_span(1 << 24);
						t.v[2][c] = rand_span(1 << 24);
						t.v[3][c] = t.v[1][c] + t.v[2][c] - t.v[0][c];
					end
				end
				4: begin
					for (int i = 0; i < 4; i++)
						for (int c = 0; c < 3; c++)
							t.v[i][c] = rand_span(4);
				end
				default: begin
					span = 1 << $urandom_range(24, 4);
					for (int c = 0; c < 3; c++) begin
						base = rand_span(1 << 28);
						t.v[0][c] = base;
						for (int i = 1; i < 4; i++)
							t.v[i][c] = base + rand_span(span);
					end
				end
			endcase
			send_tet(t);
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle = 29;
		recv_idle = 74;
		test_directed();
		test_random(100);
		send_idle = 74;
		recv_idle = 29;
		test_random(100);
		send_idle = 0;
		recv_idle = 0;
		test_random(100);
		in_ch.valid <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d tetrahedra (%0d degenerate), checked %0d gradient rows",
			sent_tets, flat_tets, checked_rows);
		$display("stall mixes covered: sender-heavy, receiver-heavy, none; %0d mismatches",
			errors);
		if (errors == 0 && expected_rows.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tlsg_pkg.sv
hdl/tlsg_in_if.sv
hdl/tlsg_out_if.sv
hdl/tlsg_front.sv
hdl/tlsg_fifo.sv
hdl/tlsg_back.sv
hdl/tet_linear_shape_gradients.sv
dv/testbench.sv
